[src/bsq_pkg.sv]
package bsq_pkg;

    localparam int COORD_BITS = 12;
    localparam int EXT_BITS   = COORD_BITS + 2;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MOTION_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE_SIZE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_COLOR  = 3'd5;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam logic                  MODE_SERPENTINE = 1'b0;
    localparam logic                  MODE_DIAGONAL   = 1'b1;
    localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST  = COORD_BITS'(1280);
    localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST = COORD_BITS'(720);
    localparam logic [COORD_BITS-1:0] SQUARE_SIZE_RST  = COORD_BITS'(100);
    localparam logic [COORD_BITS-1:0] STEP_SIZE_RST    = COORD_BITS'(8);
    localparam logic [23:0]           START_COLOR_RST  = 24'hFF8080;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } color_t;

    typedef struct packed {
        logic                  motion_mode;
        logic [COORD_BITS-1:0] frame_width;
        logic [COORD_BITS-1:0] frame_height;
        logic [COORD_BITS-1:0] square_size;
        logic [COORD_BITS-1:0] step_size;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        color_t                color;
    } sq_t;

endpackage

[src/bsq_cover.sv]
module bsq_cover
    import bsq_pkg::*;
(
    input  logic [1:0]            plane,
    input  logic [COORD_BITS-1:0] sample_row,
    input  logic [COORD_BITS-1:0] sample_col,
    input  logic [7:0]            background,
    input  logic [COORD_BITS-1:0] square_size,
    input  sq_t                   sq,
    output logic [7:0]            out_sample,
    output logic                  covered
);

    logic                is_luma;
    logic                is_chroma;
    logic [EXT_BITS-1:0] lo_r;
    logic [EXT_BITS-1:0] hi_r;
    logic [EXT_BITS-1:0] lo_c;
    logic [EXT_BITS-1:0] hi_c;
    logic [EXT_BITS-1:0] end_r;
    logic [EXT_BITS-1:0] end_c;
    logic                hit_r;
    logic                hit_c;
    logic [7:0]          color;

    assign is_luma   = (plane == PLANE_Y);
    assign is_chroma = (plane == PLANE_U) || (plane == PLANE_V);

    // chroma sample spans a 2x2 luma block
    assign lo_r = is_luma ? {2'b00, sample_row} : {1'b0, sample_row, 1'b0};
    assign hi_r = is_luma ? {2'b00, sample_row} : {1'b0, sample_row, 1'b1};
    assign lo_c = is_luma ? {2'b00, sample_col} : {1'b0, sample_col, 1'b0};
    assign hi_c = is_luma ? {2'b00, sample_col} : {1'b0, sample_col, 1'b1};

    assign end_r = {2'b00, sq.row} + {2'b00, square_size};
    assign end_c = {2'b00, sq.col} + {2'b00, square_size};

    assign hit_r = (hi_r >= {2'b00, sq.row}) && (lo_r < end_r);
    assign hit_c = (hi_c >= {2'b00, sq.col}) && (lo_c < end_c);

    always_comb
    begin
        case (plane)
            PLANE_Y: color = sq.color.y;
            PLANE_U: color = sq.color.u;
            default: color = sq.color.v;
        endcase
    end

    assign covered    = (is_luma || is_chroma) && (square_size != '0) && hit_r && hit_c;
    assign out_sample = covered ? color : background;

endmodule

[src/bsq_motion.sv]
module bsq_motion
    import bsq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     color_load,
    input  logic [CFG_DATA_BITS-1:0] color_init,
    input  logic                     step_en,
    input  color_t                   next_color,
    output sq_t                      sq
);

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  right_reg, right_next;
    logic                  down_reg, down_next;
    color_t                color_reg, color_next;

    logic [EXT_BITS-1:0]   sum_c, sum_r;
    logic                  fit_right, fit_down;
    logic [COORD_BITS-1:0] col_add, row_add, col_sub, row_sub;
    logic                  col_gt, row_gt;
    logic signed [EXT_BITS-1:0] dist_w, dist_h, pos_c, pos_r;
    logic                  bounced;

    assign sum_c = {2'b00, col_reg} + {2'b00, cfg.step_size} + {2'b00, cfg.square_size};
    assign sum_r = {2'b00, row_reg} + {2'b00, cfg.step_size} + {2'b00, cfg.square_size};
    assign fit_right = (sum_c <= {2'b00, cfg.frame_width});
    assign fit_down  = (sum_r <= {2'b00, cfg.frame_height});

    assign col_add = col_reg + cfg.step_size;
    assign row_add = row_reg + cfg.step_size;
    assign col_gt  = (col_reg > cfg.step_size);
    assign row_gt  = (row_reg > cfg.step_size);
    assign col_sub = col_gt ? (col_reg - cfg.step_size) : '0;
    assign row_sub = row_gt ? (row_reg - cfg.step_size) : '0;

    assign pos_c  = $signed({2'b00, col_reg});
    assign pos_r  = $signed({2'b00, row_reg});
    assign dist_w = $signed({2'b00, cfg.frame_width}) - pos_c;
    assign dist_h = $signed({2'b00, cfg.frame_height}) - pos_r;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        right_next = right_reg;
        down_next  = down_reg;
        color_next = color_reg;
        bounced    = 1'b0;

        if (step_en)
        begin
            if (cfg.motion_mode == MODE_DIAGONAL)
            begin
                if (right_reg && down_reg)
                begin
                    if (fit_right && fit_down)
                    begin
                        col_next = col_add;
                        row_next = row_add;
                    end
                    else
                    begin
                        bounced = 1'b1;
                        if (dist_w < dist_h)
                            right_next = 1'b0;
                        else
                            down_next = 1'b0;
                    end
                end
                else if (right_reg)
                begin
                    if (fit_right && (row_reg != '0))
                    begin
                        col_next = col_add;
                        row_next = row_sub;
                    end
                    else
                    begin
                        bounced = 1'b1;
                        if (dist_w < pos_r)
                            right_next = 1'b0;
                        else
                            down_next = 1'b1;
                    end
                end
                else if (down_reg)
                begin
                    if ((col_reg != '0) && fit_down)
                    begin
                        col_next = col_sub;
                        row_next = row_add;
                    end
                    else
                    begin
                        bounced = 1'b1;
                        if (pos_c < dist_h)
                            right_next = 1'b1;
                        else
                            down_next = 1'b0;
                    end
                end
                else
                begin
                    if ((col_reg != '0) && (row_reg != '0))
                    begin
                        col_next = col_sub;
                        row_next = row_sub;
                    end
                    else
                    begin
                        bounced = 1'b1;
                        if (col_reg < row_reg)
                            right_next = 1'b1;
                        else
                            down_next = 1'b1;
                    end
                end
            end
            else
            begin
                if (right_reg ? fit_right : col_gt)
                begin
                    col_next = right_reg ? col_add : col_sub;
                end
                else
                begin
                    // edge reached: turn round and take one row step, or reverse the row direction at the last row
                    bounced    = 1'b1;
                    right_next = !right_reg;
                    if (down_reg)
                    begin
                        if (fit_down)
                            row_next = row_add;
                        else
                            down_next = 1'b0;
                    end
                    else
                    begin
                        if (row_gt)
                            row_next = row_sub;
                        else
                            down_next = 1'b1;
                    end
                end
            end

            if (bounced)
                color_next = next_color;
        end
        else if (color_load)
        begin
            color_next = color_t'(color_init);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            right_reg <= 1'b1;
            down_reg  <= 1'b1;
            color_reg <= color_t'(START_COLOR_RST);
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            right_reg <= right_next;
            down_reg  <= down_next;
            color_reg <= color_next;
        end
    end

    assign sq.col   = col_reg;
    assign sq.row   = row_reg;
    assign sq.color = color_reg;

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(col_reg) && $stable(row_reg) && $stable(right_reg)
                     && $stable(down_reg))
        else $error("square moved without a frame end");

    a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en && !color_load |=> $stable(color_reg))
        else $error("colour changed without bounce or load");

    a_dir_bounce: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !bounced |=> $stable(right_reg) && $stable(down_reg)
                                && $stable(color_reg))
        else $error("direction or colour changed without a bounce");

endmodule

[src/bouncing_square_yuv420_overlay_top.sv]
// A result reaches the master side through the input register, then the result register.
// Throughput: one sample per clock while m_tready is high; the square moves as a
// frame-end sample leaves the input register, so the next sample already sees it.
// Reset (rst_n, asynchronous, active low) empties both registers, restores the
// register defaults and puts the square at the top-left corner moving down-right.
module bouncing_square_yuv420_overlay_top
    import bsq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [55:0]              s_tdata,   // sample_row, sample_col, background,
                                                // next_y, next_u, next_v
    input  logic [1:0]               s_tuser,   // plane
    input  logic                     s_tlast,   // frame_end
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // out_sample
    output logic                     m_tuser,   // covered
    output logic                     m_tlast,   // frame_last
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        cfg_we;
    logic        color_load;

    logic        s1_valid_reg, s1_valid_next;
    logic [55:0] s1_data_reg;
    logic [1:0]  s1_plane_reg;
    logic        s1_last_reg;
    logic        advance;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_sample_reg;
    logic        covered_reg;
    logic        last_reg;

    logic [7:0]  cov_sample;
    logic        cov_hit;
    color_t      next_color;
    sq_t         sq;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next   = cfg_reg;
        color_load = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOTION_MODE:  cfg_next.motion_mode  = cfg_data[0];
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[COORD_BITS-1:0];
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[COORD_BITS-1:0];
                CFG_SQUARE_SIZE:  cfg_next.square_size  = cfg_data[COORD_BITS-1:0];
                CFG_STEP_SIZE:    cfg_next.step_size    = cfg_data[COORD_BITS-1:0];
                CFG_START_COLOR:  color_load = 1'b1;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_mode  <= MODE_DIAGONAL;
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.square_size  <= SQUARE_SIZE_RST;
            cfg_reg.step_size    <= STEP_SIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance the input register whenever the result register is free or draining
    assign advance        = !out_valid_reg || m_tready;
    assign s_tready       = !s1_valid_reg || advance;
    assign s1_valid_next  = (s_tvalid && s_tready) || (s1_valid_reg && !advance);
    assign out_valid_next = (s1_valid_reg && advance) || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_data_reg  <= s_tdata;
            s1_plane_reg <= s_tuser;
            s1_last_reg  <= s_tlast;
        end
        if (s1_valid_reg && advance)
        begin
            out_sample_reg <= cov_sample;
            covered_reg    <= cov_hit;
            last_reg       <= s1_last_reg;
        end
    end

    assign next_color.y = s1_data_reg[39:32];
    assign next_color.u = s1_data_reg[47:40];
    assign next_color.v = s1_data_reg[55:48];

    bsq_cover u_cover (
        .plane       (s1_plane_reg),
        .sample_row  (s1_data_reg[11:0]),
        .sample_col  (s1_data_reg[23:12]),
        .background  (s1_data_reg[31:24]),
        .square_size (cfg_reg.square_size),
        .sq          (sq),
        .out_sample  (cov_sample),
        .covered     (cov_hit)
    );

    bsq_motion u_motion (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .color_load (color_load),
        .color_init (cfg_data),
        .step_en    (s1_valid_reg && advance && s1_last_reg),
        .next_color (next_color),
        .sq         (sq)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = covered_reg;
    assign m_tlast  = last_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_data_reg)
                                     && $stable(s1_last_reg))
        else $error("input register lost a sample while stalled");

    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("transfer did not fill the input register");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> m_tvalid && (m_tlast == $past(s1_last_reg)))
        else $error("result register not loaded from the input register");

endmodule
